// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables the check.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked implication: when ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/deq_pkg.sv =====
// Package of the double-ended queue: operation and status codes and word types.
// Depends on nothing; used by the top level and its checker.
package deq_pkg;

  // Fixed field widths of the command and result words.
  localparam int unsigned ModeW  = 3;
  localparam int unsigned PointW = 64;
  localparam int unsigned IndexW = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 9;

  // Operation codes; the two remaining codes are no-ops.
  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_TOP = 3'd0,
    MODE_PUSH_BOT = 3'd1,
    MODE_POP_TOP  = 3'd2,
    MODE_POP_BOT  = 3'd3,
    MODE_PEEK_TOP = 3'd4,
    MODE_PEEK_BOT = 3'd5
  } mode_e;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Command word.
  typedef struct packed {
    mode_e              mode;
    logic [PointW-1:0]  point_in;
    logic [IndexW-1:0]  peek_index;
  } deq_in_t;

  // Result word.
  typedef struct packed {
    logic [PointW-1:0]  point_out;
    status_e            status;
    logic [CountW-1:0]  item_count;
  } deq_out_t;

endpackage

// ===== rtl/deq_ram.sv =====
// Single-port ring storage of the double-ended queue with a registered read.
// Depends on nothing; instantiated by double_ended_queue.
module deq_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue: a word is taken whenever start is high, busy
// never rises, so one operation enters every cycle. Its result appears on
// rsp_o with done_o high in the next cycle, read straight from the
// registered port of the single-port ring memory; the receiver must take it.
// Pointer and count update at the edge that accepts the word, so back-to-back
// operations see each other's effect without forwarding. Memory contents
// are undefined after reset; only live entries are ever read.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned POINT_WIDTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  deq_in_t  req_i,
  output logic     done_o,
  output deq_out_t rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > IndexW) ? CW : IndexW;
  localparam int unsigned XW = (CW > CountW) ? CW : CountW;

  logic            acc;
  logic [AW-1:0]   top_q, top_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            done_q;
  status_e         status_q, st_d;
  logic            rd_q, is_read;
  logic            is_write;
  logic            op_ok;
  logic            full, empty;
  logic [IW-1:0]   cnt_w, idx_w, bot_off_w;
  logic            idx_ok;
  logic [AW-1:0]   off;
  logic [AW:0]     sum;
  logic [AW-1:0]   slot;
  logic [AW-1:0]   top_inc;
  logic [POINT_WIDTH-1:0] rdata;
  logic [PointW-1:0]      pt_ext;
  logic [XW-1:0]          cnt_ext;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Occupancy and peek range checks.
  assign full      = (cnt_q == CW'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign cnt_w     = IW'(cnt_q);
  assign idx_w     = IW'(req_i.peek_index);
  assign idx_ok    = (idx_w < cnt_w);
  assign bot_off_w = cnt_w - idx_w - IW'(1);

  // Decode the operation into a ring offset and the access it needs.
  always_comb begin
    off      = '0;
    is_write = 1'b0;
    is_read  = 1'b0;
    st_d     = ST_OK;
    case (req_i.mode)
      MODE_PUSH_TOP: begin
        off      = AW'(DEPTH - 1);
        is_write = !full;
        st_d     = full ? ST_FULL : ST_OK;
      end
      MODE_PUSH_BOT: begin
        off      = cnt_w[AW-1:0];
        is_write = !full;
        st_d     = full ? ST_FULL : ST_OK;
      end
      MODE_POP_TOP: begin
        off     = '0;
        is_read = !empty;
        st_d    = empty ? ST_EMPTY : ST_OK;
      end
      MODE_POP_BOT: begin
        off     = AW'(cnt_w - IW'(1));
        is_read = !empty;
        st_d    = empty ? ST_EMPTY : ST_OK;
      end
      MODE_PEEK_TOP: begin
        off     = idx_w[AW-1:0];
        is_read = idx_ok;
        st_d    = idx_ok ? ST_OK : ST_RANGE;
      end
      MODE_PEEK_BOT: begin
        off     = bot_off_w[AW-1:0];
        is_read = idx_ok;
        st_d    = idx_ok ? ST_OK : ST_RANGE;
      end
      default: begin
        off = '0;
      end
    endcase
  end

  assign op_ok = (st_d == ST_OK);

  // Ring slot of the selected entry: top plus offset, folded once.
  assign sum  = {1'b0, top_q} + {1'b0, off};
  assign slot = (sum >= (AW+1)'(DEPTH)) ? AW'(sum - (AW+1)'(DEPTH)) : sum[AW-1:0];
  assign top_inc = (top_q == AW'(DEPTH - 1)) ? '0 : top_q + AW'(1);

  // Next pointer and count.
  always_comb begin
    top_d = top_q;
    cnt_d = cnt_q;
    if (acc && op_ok) begin
      case (req_i.mode)
        MODE_PUSH_TOP: begin
          top_d = slot;
          cnt_d = cnt_q + CW'(1);
        end
        MODE_PUSH_BOT: begin
          cnt_d = cnt_q + CW'(1);
        end
        MODE_POP_TOP: begin
          top_d = top_inc;
          cnt_d = cnt_q - CW'(1);
        end
        MODE_POP_BOT: begin
          cnt_d = cnt_q - CW'(1);
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  // Control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      rd_q     <= 1'b0;
      status_q <= ST_OK;
    end else begin
      top_q    <= top_d;
      cnt_q    <= cnt_d;
      done_q   <= acc;
      rd_q     <= acc && is_read;
      status_q <= st_d;
    end
  end

  deq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (POINT_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (acc && is_write),
    .re_i    (acc && is_read),
    .addr_i  (slot),
    .wdata_i (req_i.point_in[POINT_WIDTH-1:0]),
    .rdata_o (rdata)
  );

  // Result word: data only for successful reads, count after the operation.
  always_comb begin
    pt_ext  = '0;
    cnt_ext = '0;
    if (rd_q) begin
      pt_ext[POINT_WIDTH-1:0] = rdata;
    end
    cnt_ext[CW-1:0] = cnt_q;
  end

  assign done_o           = done_q;
  assign rsp_o.point_out  = pt_ext;
  assign rsp_o.status     = status_q;
  assign rsp_o.item_count = cnt_ext[CountW-1:0];

endmodule

// ===== rtl/deq_chk.sv =====
// Port-level checker of the double-ended queue and its bind to the top level.
// Depends on deq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module deq_chk
  import deq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input deq_in_t  req_i,
  input logic     done_o,
  input deq_out_t rsp_o
);

  // Every accepted word yields exactly one result in the next cycle.
  `ASSERT_CLK(a_done_follows, clk_i, rst_ni, (start && !busy) |=> done_o, "no result after word")
  `ASSERT_IMPL(a_done_cause, clk_i, rst_ni, done_o, $past(start && !busy), "result without word")

  // Failed operations return no data.
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, done_o && rsp_o.status != ST_OK, rsp_o.point_out == '0, "data on error")

  // An empty pop reports an empty queue.
  `ASSERT_IMPL(a_empty_cnt, clk_i, rst_ni, done_o && rsp_o.status == ST_EMPTY, rsp_o.item_count == '0, "empty with items")

  // A range error comes only from a peek.
  `ASSERT_IMPL(a_range_peek, clk_i, rst_ni, done_o && rsp_o.status == ST_RANGE, $past(req_i.mode == MODE_PEEK_TOP || req_i.mode == MODE_PEEK_BOT), "range error not on peek")

endmodule

bind double_ended_queue deq_chk u_deq_chk (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the double-ended queue: directed table, then weighted random traffic.
// Depends on deq_pkg and the double_ended_queue top level; results are checked by a shadow queue.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int unsigned RING_SLOTS  = 256;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_WORDS = 300;

  // The two unused operation codes; the block treats them as no-ops.
  localparam logic [ModeW-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_7 = 3'd7;

  // Leanings of a random segment.
  localparam int LEAN_GROW    = 0;
  localparam int LEAN_SHRINK  = 1;
  localparam int LEAN_BALANCE = 2;

  // One directed row; known rows carry a hand-written result.
  typedef struct packed {
    logic [ModeW-1:0]  op;
    logic [PointW-1:0] pt;
    logic [IndexW-1:0] idx;
    bit                known;
    logic [PointW-1:0] want_pt;
    status_e           want_st;
    logic [CountW-1:0] want_cnt;
  } row_t;

  // What the driver remembers about each word it offers.
  typedef struct packed {
    bit       known;
    deq_out_t value;
  } note_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  deq_in_t  cmd_word;
  logic     done_o;
  deq_out_t rsp_o;

  // Shadow copy of the queue state.
  logic [PointW-1:0] shadow_ring [RING_SLOTS];
  logic [7:0]        shadow_top;
  logic [CountW-1:0] shadow_count;

  deq_out_t pending_results [$];
  note_t    issued_notes [$];
  int unsigned words_taken;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned random_words;
  bit          no_idle;
  bit          filled;

  row_t directed_rows [23] = '{
    // Empty queue: pops fail, peeks are out of range, spare codes do nothing.
    '{MODE_POP_TOP,  64'h0, 8'd0,   1'b1, 64'h0, ST_EMPTY, 9'd0},
    '{MODE_POP_BOT,  64'h0, 8'd0,   1'b1, 64'h0, ST_EMPTY, 9'd0},
    '{MODE_PEEK_TOP, 64'h0, 8'd0,   1'b1, 64'h0, ST_RANGE, 9'd0},
    '{MODE_PEEK_BOT, 64'h0, 8'd255, 1'b1, 64'h0, ST_RANGE, 9'd0},
    '{MODE_SPARE_6,  64'h0, 8'd0,   1'b1, 64'h0, ST_OK,    9'd0},
    '{MODE_SPARE_7,  {64{1'b1}}, 8'd255, 1'b1, 64'h0, ST_OK, 9'd0},
    // Fill from both ends with extreme points.
    '{MODE_PUSH_TOP, {64{1'b1}}, 8'd0, 1'b1, 64'h0, ST_OK, 9'd1},
    '{MODE_PUSH_BOT, 64'h0, 8'd255, 1'b1, 64'h0, ST_OK, 9'd2},
    '{MODE_PUSH_TOP, 64'h8000_0000_0000_0001, 8'd0, 1'b1, 64'h0, ST_OK, 9'd3},
    // Peeks from each end, including the last valid index and one past it.
    '{MODE_PEEK_TOP, 64'h0, 8'd0, 1'b1, 64'h8000_0000_0000_0001, ST_OK, 9'd3},
    '{MODE_PEEK_TOP, 64'h0, 8'd2, 1'b0, 64'h0, ST_OK, 9'd0},
    '{MODE_PEEK_BOT, 64'h0, 8'd0, 1'b1, 64'h0, ST_OK, 9'd3},
    '{MODE_PEEK_BOT, 64'h0, 8'd2, 1'b0, 64'h0, ST_OK, 9'd0},
    '{MODE_PEEK_TOP, 64'h0, 8'd3, 1'b1, 64'h0, ST_RANGE, 9'd3},
    '{MODE_PEEK_BOT, 64'h0, 8'd255, 1'b1, 64'h0, ST_RANGE, 9'd3},
    '{MODE_PUSH_BOT, 64'hA5A5_5A5A_A5A5_5A5A, 8'd0, 1'b1, 64'h0, ST_OK, 9'd4},
    // Drain from both ends, then pop once more on empty.
    '{MODE_POP_BOT, 64'h0, 8'd0, 1'b1, 64'hA5A5_5A5A_A5A5_5A5A, ST_OK, 9'd3},
    '{MODE_POP_TOP, 64'h0, 8'd0, 1'b1, 64'h8000_0000_0000_0001, ST_OK, 9'd2},
    '{MODE_POP_TOP, 64'h0, 8'd0, 1'b1, {64{1'b1}}, ST_OK, 9'd1},
    '{MODE_POP_BOT, 64'h0, 8'd0, 1'b1, 64'h0, ST_OK, 9'd0},
    '{MODE_POP_BOT, 64'h0, 8'd0, 1'b1, 64'h0, ST_EMPTY, 9'd0},
    '{MODE_PUSH_BOT, 64'h0123_4567_89AB_CDEF, 8'd0, 1'b1, 64'h0, ST_OK, 9'd1},
    '{MODE_POP_TOP, 64'h0, 8'd0, 1'b1, 64'h0123_4567_89AB_CDEF, ST_OK, 9'd0}
  };

  double_ended_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (cmd_word),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one word to the shadow queue and return the result it must produce.
  function automatic deq_out_t deq_apply(deq_in_t w);
    deq_out_t   r;
    logic [7:0] slot;
    r.point_out = '0;
    r.status = ST_OK;
    case (w.mode)
      MODE_PUSH_TOP, MODE_PUSH_BOT: begin
        if (shadow_count >= RING_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          if (w.mode == MODE_PUSH_TOP) begin
            shadow_top = shadow_top - 8'd1;
            slot = shadow_top;
          end else begin
            slot = shadow_top + shadow_count[7:0];
          end
          shadow_ring[slot] = w.point_in;
          shadow_count = shadow_count + CountW'(1);
        end
      end
      MODE_POP_TOP, MODE_POP_BOT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (w.mode == MODE_POP_TOP) begin
            r.point_out = shadow_ring[shadow_top];
            shadow_top = shadow_top + 8'd1;
          end else begin
            slot = shadow_top + shadow_count[7:0] - 8'd1;
            r.point_out = shadow_ring[slot];
          end
          shadow_count = shadow_count - CountW'(1);
        end
      end
      MODE_PEEK_TOP, MODE_PEEK_BOT: begin
        if (CountW'(w.peek_index) >= shadow_count) begin
          r.status = ST_RANGE;
        end else if (w.mode == MODE_PEEK_TOP) begin
          slot = shadow_top + w.peek_index;
          r.point_out = shadow_ring[slot];
        end else begin
          slot = shadow_top + shadow_count[7:0] - 8'd1 - w.peek_index;
          r.point_out = shadow_ring[slot];
        end
      end
      default: begin
      end
    endcase
    r.item_count = shadow_count;
    return r;
  endfunction

  function automatic deq_in_t pack_word(logic [ModeW-1:0] op, logic [PointW-1:0] pt,
                                        logic [IndexW-1:0] idx);
    return deq_in_t'({op, pt, idx});
  endfunction

  function automatic logic [PointW-1:0] draw_point();
    case ($urandom_range(0, 9))
      0:       return {PointW{1'b1}};
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random word; peeks mostly hit a live entry so the data path gets exercised.
  function automatic deq_in_t draw_word(int lean);
    int               roll;
    int               push_cut;
    int               pop_cut;
    logic [ModeW-1:0] op;
    logic [IndexW-1:0] idx;
    push_cut = (lean == LEAN_GROW) ? 55 : (lean == LEAN_SHRINK) ? 20 : 35;
    pop_cut = push_cut + ((lean == LEAN_GROW) ? 15 : (lean == LEAN_SHRINK) ? 50 : 30);
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      op = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < push_cut) op = $urandom_range(0, 1) ? MODE_PUSH_TOP : MODE_PUSH_BOT;
      else if (roll < pop_cut) op = $urandom_range(0, 1) ? MODE_POP_TOP : MODE_POP_BOT;
      else op = $urandom_range(0, 1) ? MODE_PEEK_TOP : MODE_PEEK_BOT;
    end
    if (shadow_count != 0 && $urandom_range(0, 9) < 8) begin
      idx = IndexW'($urandom_range(0, shadow_count - 1));
    end else begin
      idx = IndexW'($urandom_range(0, 255));
    end
    return pack_word(op, draw_point(), idx);
  endfunction

  // Offer one word, after a random gap unless no_idle is set; returns at the falling edge after it was taken.
  task automatic issue(deq_in_t w, bit known, deq_out_t value);
    int unsigned gap;
    int unsigned target;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    issued_notes.push_back(note_t'{known, value});
    target = words_taken + 1;
    start <= 1'b1;
    cmd_word <= w;
    do @(negedge clk_i); while (words_taken != target);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0 || issued_notes.size() != 0);
  endtask

  task automatic issue_random(int lean);
    issue(draw_word(lean), 1'b0, '0);
    random_words++;
  endtask

  // Accept words, predict their results and check the results that come back.
  always @(posedge clk_i) begin
    deq_out_t want;
    deq_out_t guess;
    note_t    note;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, rsp_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_o.point_out !== want.point_out) begin
            $display("%0t: point_out expected %h got %h", $time, want.point_out,
                     rsp_o.point_out);
            error_count++;
          end
          if (rsp_o.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp_o.status);
            error_count++;
          end
          if (rsp_o.item_count !== want.item_count) begin
            $display("%0t: item_count expected %0d got %0d", $time, want.item_count,
                     rsp_o.item_count);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        note = issued_notes.pop_front();
        guess = deq_apply(cmd_word);
        pending_results.push_back(note.known ? note.value : guess);
        words_taken++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue regression: fail");
      $finish;
    end
  end

  initial begin
    deq_out_t row_out;
    int       lean;
    int       seg_len;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_word = '0;
    shadow_top = '0;
    shadow_count = '0;
    words_taken = 0;
    error_count = 0;
    cycle_count = 0;
    random_words = 0;
    no_idle = 1'b0;
    filled = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table.
    foreach (directed_rows[i]) begin
      row_out.point_out = directed_rows[i].want_pt;
      row_out.status = directed_rows[i].want_st;
      row_out.item_count = directed_rows[i].want_cnt;
      no_idle = (i >= 6 && i < 12);
      issue(pack_word(directed_rows[i].op, directed_rows[i].pt, directed_rows[i].idx),
            directed_rows[i].known, row_out);
    end
    settle();

    // Random segments, each with a leaning and either random gaps or none.
    while (random_words < RANDOM_WORDS) begin
      if (!filled && random_words >= 60) begin
        // Fill to the brim, push into the full queue and peek at its far ends.
        settle();
        no_idle = 1'($urandom_range(0, 1));
        while (shadow_count < RING_SLOTS) begin
          issue(pack_word($urandom_range(0, 1) ? MODE_PUSH_TOP : MODE_PUSH_BOT,
                          draw_point(), 8'd0), 1'b0, '0);
          random_words++;
        end
        repeat (3) begin
          issue(pack_word($urandom_range(0, 1) ? MODE_PUSH_TOP : MODE_PUSH_BOT,
                          draw_point(), 8'd0), 1'b0, '0);
        end
        issue(pack_word(MODE_PEEK_TOP, '0, 8'd255), 1'b0, '0);
        issue(pack_word(MODE_PEEK_BOT, '0, 8'd255), 1'b0, '0);
        issue(pack_word(MODE_PEEK_TOP, '0, 8'd0), 1'b0, '0);
        filled = 1'b1;
      end
      lean = $urandom_range(LEAN_GROW, LEAN_BALANCE);
      seg_len = $urandom_range(10, 40);
      no_idle = ($urandom_range(0, 2) == 0);
      repeat (seg_len) issue_random(lean);
    end

    // Drain to empty and pop past the bottom once more.
    no_idle = 1'b0;
    while (shadow_count != 0) begin
      issue(pack_word($urandom_range(0, 1) ? MODE_POP_TOP : MODE_POP_BOT, '0, 8'd0),
            1'b0, '0);
    end
    issue(pack_word(MODE_POP_BOT, '0, 8'd0), 1'b0, '0);
    issue(pack_word(MODE_PEEK_BOT, '0, 8'd0), 1'b0, '0);

    settle();
    repeat (4) @(negedge clk_i);
    if (error_count == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule
